// File: hdl/chrs_pkg.sv
// shared types, constants and tables for the three-tap modulated chorus
// no dependencies
package chrs_pkg;

  localparam int DEPTH    = 1024;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int FILL_W   = ADDR_W + 1;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 24;
  localparam int STEP_W   = 24;
  localparam int BASE_W   = 18;
  localparam int MODD_W   = 16;
  localparam int PADDR_W  = 4;

  localparam logic [PHASE_W-1:0] THIRD_TURN = PHASE_W'((64'd1 << PHASE_W) / 3);
  localparam logic [PHASE_W-1:0] TWO_THIRD  = PHASE_W'(2 * ((64'd1 << PHASE_W) / 3));

  localparam logic [STEP_W-1:0] FAST_STEP_RST  = STEP_W'(2377);
  localparam logic [STEP_W-1:0] SLOW_STEP_RST  = STEP_W'(245);
  localparam logic [BASE_W-1:0] BASE_DELAY_RST = BASE_W'(61440);
  localparam logic [MODD_W-1:0] MOD_DEPTH_RST  = MODD_W'(18432);

  localparam int D_LO = 256;
  localparam int D_HI = (DEPTH - 2) * 256;

  localparam logic [21:0] DIV3_MUL = 22'd1398102;
  localparam int          DIV_BIAS = 3 * (1 << 17);
  localparam int          OUT_BIAS = 1 << 17;

  typedef enum logic [1:0] {
    REG_FAST_STEP,
    REG_SLOW_STEP,
    REG_BASE_DELAY,
    REG_MOD_DEPTH
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SF_MUL, OP_SF_FIN, OP_SS_MUL, OP_SS_FIN, OP_MF, OP_MS,
    OP_MD, OP_DM, OP_DL, OP_RD0, OP_RD1, OP_RD2, OP_TM, OP_TA, OP_DQ, OP_DF
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SF_MUL, ST_SF_FIN, ST_SS_MUL, ST_SS_FIN, ST_MF, ST_MS, ST_MD,
    ST_DM, ST_DL, ST_RD0, ST_RD1, ST_RD2, ST_TM, ST_TA, ST_DQ, ST_DF
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] tap;
  } cmd_t;

  function automatic logic [15:0] quarter_sine(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3212;
      5'd2:    v = 16'd6393;
      5'd3:    v = 16'd9512;
      5'd4:    v = 16'd12539;
      5'd5:    v = 16'd15446;
      5'd6:    v = 16'd18205;
      5'd7:    v = 16'd20787;
      5'd8:    v = 16'd23170;
      5'd9:    v = 16'd25329;
      5'd10:   v = 16'd27245;
      5'd11:   v = 16'd28898;
      5'd12:   v = 16'd30273;
      5'd13:   v = 16'd31356;
      5'd14:   v = 16'd32137;
      5'd15:   v = 16'd32609;
      default: v = 16'd32767;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] fast_weight(input logic [1:0] t);
    logic [15:0] w;
    case (t)
      2'd0:    w = 16'd6652;
      2'd1:    w = 16'd8126;
      default: w = 16'd8258;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] slow_weight(input logic [1:0] t);
    logic [15:0] w;
    case (t)
      2'd0:    w = 16'd20808;
      2'd1:    w = 16'd24412;
      default: w = 16'd19956;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/three_tap_modulated_chorus_top.sv
// top level of the three-tap modulated chorus: apb register file plus
// sequencer and datapath; depends on chrs_pkg, chrs_ctrl, chrs_dp
//
// input channel: sample_in_i with sample_in_valid_i / sample_in_stall_o; an item
// is taken at a clock edge with valid high and stall low
// output channel: sample_out_o with sample_out_valid_o / sample_out_stall_i
// one result item per input item; each item passes through fourteen sequencer
// steps for each of the three taps through one shared multiplier, plus load
// and final scaling; no new item is taken until the sequencer has finished
// the last one and returned to idle
// the finished result sits in an output register, so the block takes the next
// item while it waits; if the receiver still stalls when the next result is
// ready, the sequencer holds in its last step until the register frees
// reset clears phases, write pointer and fill count; the delay store is not
// swept, entries beyond the fill count read as zero
// configuration: apb port, registers at byte addresses 0, 4, 8, 12
module three_tap_modulated_chorus_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [chrs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic [chrs_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                           sample_in_valid_i,
  output logic                           sample_in_stall_o,
  output logic [chrs_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                           sample_out_valid_o,
  input  logic                           sample_out_stall_i
);
  import chrs_pkg::*;

  logic [STEP_W-1:0] fast_step_q, slow_step_q;
  logic [BASE_W-1:0] base_delay_q;
  logic [MODD_W-1:0] mod_depth_q;
  logic              wr_en;
  reg_idx_e          reg_idx;
  cmd_t              cmd;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_step_q  <= FAST_STEP_RST;
      slow_step_q  <= SLOW_STEP_RST;
      base_delay_q <= BASE_DELAY_RST;
      mod_depth_q  <= MOD_DEPTH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FAST_STEP:  fast_step_q  <= pwdata[STEP_W-1:0];
        REG_SLOW_STEP:  slow_step_q  <= pwdata[STEP_W-1:0];
        REG_BASE_DELAY: base_delay_q <= pwdata[BASE_W-1:0];
        REG_MOD_DEPTH:  mod_depth_q  <= pwdata[MODD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FAST_STEP:  prdata = 32'(fast_step_q);
      REG_SLOW_STEP:  prdata = 32'(slow_step_q);
      REG_BASE_DELAY: prdata = 32'(base_delay_q);
      REG_MOD_DEPTH:  prdata = 32'(mod_depth_q);
      default:        prdata = '0;
    endcase
  end

  chrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_in_valid_i),
    .in_stall_o  (sample_in_stall_o),
    .out_valid_o (sample_out_valid_o),
    .out_stall_i (sample_out_stall_i),
    .cmd_o       (cmd)
  );

  chrs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_in_i  (sample_in_i),
    .fast_step_i  (fast_step_q),
    .slow_step_i  (slow_step_q),
    .base_delay_i (base_delay_q),
    .mod_depth_i  (mod_depth_q),
    .sample_out_o (sample_out_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_in_valid_i && !sample_in_stall_o) |=> sample_in_stall_o)
    else $error("input taken again right after an accepted item");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sample_out_valid_o) |-> $past(sample_in_stall_o))
    else $error("result raised without an item in progress");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_LOAD) |-> (sample_in_valid_i && !sample_in_stall_o))
    else $error("store written without an accepted item");

endmodule

// File: hdl/chrs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module chrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/chrs_ctrl.sv
// sequencer for the chorus: steps each item through sine, delay and tap phases
// depends on chrs_pkg
module chrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output chrs_pkg::cmd_t cmd_o
);
  import chrs_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] tap_q, tap_d;
  logic       out_valid_q, out_valid_d;
  logic       done;

  assign done = out_valid_q && out_stall_i;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SF_MUL;
          tap_d   = 2'd0;
        end
      end
      ST_SF_MUL: state_d = ST_SF_FIN;
      ST_SF_FIN: state_d = ST_SS_MUL;
      ST_SS_MUL: state_d = ST_SS_FIN;
      ST_SS_FIN: state_d = ST_MF;
      ST_MF:     state_d = ST_MS;
      ST_MS:     state_d = ST_MD;
      ST_MD:     state_d = ST_DM;
      ST_DM:     state_d = ST_DL;
      ST_DL:     state_d = ST_RD0;
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_RD2;
      ST_RD2:    state_d = ST_TM;
      ST_TM:     state_d = ST_TA;
      ST_TA: begin
        if (tap_q == 2'd2) begin
          state_d = ST_DQ;
        end else begin
          state_d = ST_SF_MUL;
          tap_d   = tap_q + 2'd1;
        end
      end
      ST_DQ:     state_d = ST_DF;
      ST_DF: begin
        if (!done) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.tap   = tap_q;
    cmd_o.op    = OP_NONE;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      ST_SF_MUL: cmd_o.op = OP_SF_MUL;
      ST_SF_FIN: cmd_o.op = OP_SF_FIN;
      ST_SS_MUL: cmd_o.op = OP_SS_MUL;
      ST_SS_FIN: cmd_o.op = OP_SS_FIN;
      ST_MF:     cmd_o.op = OP_MF;
      ST_MS:     cmd_o.op = OP_MS;
      ST_MD:     cmd_o.op = OP_MD;
      ST_DM:     cmd_o.op = OP_DM;
      ST_DL:     cmd_o.op = OP_DL;
      ST_RD0:    cmd_o.op = OP_RD0;
      ST_RD1:    cmd_o.op = OP_RD1;
      ST_RD2:    cmd_o.op = OP_RD2;
      ST_TM:     cmd_o.op = OP_TM;
      ST_TA:     cmd_o.op = OP_TA;
      ST_DQ:     cmd_o.op = OP_DQ;
      ST_DF: begin
        if (!done) begin
          cmd_o.op    = OP_DF;
          out_valid_d = 1'b1;
        end
      end
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/chrs_dp.sv
// chorus datapath: phase accumulators, sine lookup, shared multiplier,
// delay store and tap accumulation; depends on chrs_pkg and chrs_ram
module chrs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chrs_pkg::cmd_t                cmd_i,
  input  logic [chrs_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [chrs_pkg::STEP_W-1:0]   fast_step_i,
  input  logic [chrs_pkg::STEP_W-1:0]   slow_step_i,
  input  logic [chrs_pkg::BASE_W-1:0]   base_delay_i,
  input  logic [chrs_pkg::MODD_W-1:0]   mod_depth_i,
  output logic [chrs_pkg::SAMPLE_W-1:0] sample_out_o
);
  import chrs_pkg::*;

  logic [PHASE_W-1:0] fast_q, slow_q;
  logic [ADDR_W-1:0]  wp_q;
  logic [FILL_W-1:0]  fill_q;

  logic [15:0]        sv_q;
  logic               neg_q;
  logic signed [16:0] sf_q, ss_q;
  logic signed [32:0] m_q;
  logic signed [53:0] p_q;
  logic [ADDR_W-1:0]  n_q;
  logic [7:0]         f_q;
  logic               v0_q, v1_q;
  logic signed [15:0] s0_q, s1_q;
  logic signed [26:0] sum_q;
  logic [15:0]        out_q;

  logic [PHASE_W-1:0] phase_sel, offset, ph;
  logic [15:0]        p16;
  logic [14:0]        u15;
  logic [4:0]         idx;
  logic [9:0]         fr;
  logic [15:0]        base_v, diff;
  logic [16:0]        vv;
  logic signed [16:0] sine_v;
  logic signed [20:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [53:0] prod;
  logic signed [53:0] rnd_t;
  logic signed [24:0] dl, dc;
  logic signed [26:0] t27, tap_add;
  logic signed [20:0] u21;
  logic [ADDR_W-1:0]  raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic               we;

  always_comb begin
    phase_sel = (cmd_i.op == OP_SS_MUL) ? slow_q : fast_q;
    case (cmd_i.tap)
      2'd0:    offset = '0;
      2'd1:    offset = THIRD_TURN;
      default: offset = TWO_THIRD;
    endcase
    ph  = phase_sel + offset;
    p16 = ph[PHASE_W-1 -: 16];
    u15 = {1'b0, p16[13:0]};
    if (p16[14]) begin
      u15 = 15'h4000 - u15;
    end
    idx = u15[14:10];
    fr  = u15[9:0];
    if (idx >= 5'd16) begin
      base_v = quarter_sine(5'd16);
      diff   = 16'd0;
    end else begin
      base_v = quarter_sine(idx);
      diff   = quarter_sine(idx + 5'd1) - quarter_sine(idx);
    end
    vv     = {1'b0, sv_q} + {1'b0, p_q[25:10]};
    sine_v = neg_q ? -$signed(vv) : $signed(vv);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SF_MUL, OP_SS_MUL: begin
        mul_a = $signed({5'd0, diff});
        mul_b = $signed({23'd0, fr});
      end
      OP_MF: begin
        mul_a = $signed({5'd0, fast_weight(cmd_i.tap)});
        mul_b = 33'(sf_q);
      end
      OP_MS: begin
        mul_a = $signed({5'd0, slow_weight(cmd_i.tap)});
        mul_b = 33'(ss_q);
      end
      OP_DM: begin
        mul_a = $signed({5'd0, mod_depth_i});
        mul_b = m_q;
      end
      OP_TM: begin
        mul_a = 21'(17'(s1_q) - 17'(s0_q));
        mul_b = $signed({25'd0, f_q});
      end
      OP_DQ: begin
        mul_a = u21;
        mul_b = $signed({11'd0, DIV3_MUL});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = 54'(mul_a) * 54'(mul_b);
  end

  always_comb begin
    rnd_t   = p_q + 54'sd536870912;
    dl      = $signed({7'd0, base_delay_i}) + 25'($signed(rnd_t[53:30]));
    dc      = dl;
    if (dl < 25'sd256) begin
      dc = 25'(D_LO);
    end else if (dl > 25'(D_HI)) begin
      dc = 25'(D_HI);
    end
    t27     = sum_q + 27'sd384;
    u21     = 21'($signed(t27[26:8])) + 21'(DIV_BIAS);
    tap_add = 27'($signed({s0_q, 8'd0})) + 27'($signed(p_q[24:0]));
    raddr   = (cmd_i.op == OP_RD1) ? (wp_q - n_q - ADDR_W'(1)) : (wp_q - n_q);
    we      = (cmd_i.op == OP_LOAD);
  end

  chrs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (sample_in_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.op == OP_LOAD) begin
        fast_q <= fast_q + PHASE_W'(fast_step_i);
        slow_q <= slow_q + PHASE_W'(slow_step_i);
      end
      if (cmd_i.op == OP_DF) begin
        wp_q <= wp_q + ADDR_W'(1);
        if (fill_q != FILL_W'(DEPTH)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: sum_q <= '0;
      OP_SF_MUL, OP_SS_MUL: begin
        p_q   <= prod;
        sv_q  <= base_v;
        neg_q <= p16[15];
      end
      OP_SF_FIN: sf_q <= sine_v;
      OP_SS_FIN: ss_q <= sine_v;
      OP_MF:     p_q <= prod;
      OP_MS: begin
        m_q <= p_q[32:0];
        p_q <= prod;
      end
      OP_MD:     m_q <= m_q + p_q[32:0];
      OP_DM:     p_q <= prod;
      OP_DL: begin
        n_q <= dc[ADDR_W+7:8];
        f_q <= dc[7:0];
      end
      OP_RD0:    v0_q <= ({1'b0, n_q} <= fill_q);
      OP_RD1: begin
        s0_q <= v0_q ? $signed(rdata) : '0;
        v1_q <= (({1'b0, n_q} + FILL_W'(1)) <= fill_q);
      end
      OP_RD2:    s1_q <= v1_q ? $signed(rdata) : '0;
      OP_TM:     p_q <= prod;
      OP_TA:     sum_q <= sum_q + tap_add;
      OP_DQ:     p_q <= prod;
      OP_DF:     out_q <= 16'(p_q[53:22] - 32'(OUT_BIAS));
      default: ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule

// File: sim/chrs_checker.sv
// checker for the three-tap modulated chorus: follows the apb writes and both
// item channels, predicts each output sample and compares; depends on chrs_pkg
module chrs_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [chrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  input  logic [chrs_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                          sample_in_valid_i,
  input  logic                          sample_in_stall_o,
  input  logic [chrs_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                          sample_out_valid_o,
  input  logic                          sample_out_stall_i,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import chrs_pkg::*;

  localparam int SINE_TBL [17] = '{0, 3212, 6393, 9512, 12539, 15446, 18205, 20787, 23170,
                                   25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767};
  localparam longint FAST_W [3] = '{6652, 8126, 8258};
  localparam longint SLOW_W [3] = '{20808, 24412, 19956};

  logic signed [SAMPLE_W-1:0] history [DEPTH];
  logic [ADDR_W-1:0]          wr_pos;
  logic [PHASE_W-1:0]         fast_ph, slow_ph;
  logic [STEP_W-1:0]          fast_inc, slow_inc;
  logic [BASE_W-1:0]          centre;
  logic [MODD_W-1:0]          depth;
  logic [SAMPLE_W-1:0]        expected_samples [$];

  function automatic longint sine_q15(input logic [PHASE_W-1:0] ph);
    logic [15:0] p;
    int          u, idx, fr;
    longint      v;
    p = ph[PHASE_W-1 -: 16];
    u = int'(p[13:0]);
    if (p[14]) u = 16384 - u;
    idx = u >> 10;
    fr  = u & 1023;
    if (idx >= 16) v = SINE_TBL[16];
    else v = SINE_TBL[idx] + (((SINE_TBL[idx+1] - SINE_TBL[idx]) * fr) >> 10);
    return p[15] ? -v : v;
  endfunction

  function automatic longint tap_q8(input int k, input logic [PHASE_W-1:0] off);
    longint m, d, f, s0, s1;
    int     n;
    m = FAST_W[k] * sine_q15(fast_ph + off) + SLOW_W[k] * sine_q15(slow_ph + off);
    d = longint'(centre) + ((longint'(depth) * m + (64'sd1 <<< 29)) >>> 30);
    if (d < D_LO) d = D_LO;
    if (d > D_HI) d = D_HI;
    n  = int'(d >> 8);
    f  = d & 255;
    s0 = history[ADDR_W'(int'(wr_pos) - n)];
    s1 = history[ADDR_W'(int'(wr_pos) - n - 1)];
    return s0 * 256 + (s1 - s0) * f;
  endfunction

  function automatic logic [SAMPLE_W-1:0] chorus_step(input logic signed [SAMPLE_W-1:0] x);
    longint sum, y;
    fast_ph = fast_ph + fast_inc;
    slow_ph = slow_ph + slow_inc;
    history[wr_pos] = x;
    sum = tap_q8(0, '0) + tap_q8(1, THIRD_TURN) + tap_q8(2, TWO_THIRD);
    y = (sum + (longint'(768) << SAMPLE_W) + 384) / 768 - (longint'(1) << SAMPLE_W);
    wr_pos = wr_pos + 1'b1;
    return y[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      foreach (history[i]) history[i] = '0;
      wr_pos = '0;
      fast_ph = '0;
      slow_ph = '0;
      fast_inc = FAST_STEP_RST;
      slow_inc = SLOW_STEP_RST;
      centre = BASE_DELAY_RST;
      depth = MOD_DEPTH_RST;
      expected_samples.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_FAST_STEP:  fast_inc = pwdata[STEP_W-1:0];
          REG_SLOW_STEP:  slow_inc = pwdata[STEP_W-1:0];
          REG_BASE_DELAY: centre = pwdata[BASE_W-1:0];
          REG_MOD_DEPTH:  depth = pwdata[MODD_W-1:0];
          default: ;
        endcase
      end
      if (sample_out_valid_o && !sample_out_stall_i) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("chk: unexpected item, sample_out %0d", $signed(sample_out_o));
        end else begin
          want = expected_samples.pop_front();
          if (want !== sample_out_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("chk: sample_out expected %0d actual %0d", $signed(want),
                       $signed(sample_out_o));
          end
        end
      end
      if (sample_in_valid_i && !sample_in_stall_o)
        expected_samples.push_back(chorus_step(sample_in_i));
      pending = expected_samples.size();
    end
  end

endmodule

// File: sim/tb.sv
// testbench top for the three-tap modulated chorus: clock, reset, apb writes,
// sample stimulus with random gaps; depends on chrs_pkg, chrs_checker and the rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chrs_pkg::*;

  logic                clk_i, rst_ni;
  logic                psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata, prdata;
  logic [SAMPLE_W-1:0] sample_in_i, sample_out_o;
  logic                sample_in_valid_i, sample_in_stall_o;
  logic                sample_out_valid_o, sample_out_stall_i;
  int                  fail_count, pending;
  bit                  no_gaps;

  three_tap_modulated_chorus_top DUT (.*);

  chrs_checker u_chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic set_all(input logic [31:0] fs, ss, bd, md);
    drain();
    write_reg(REG_FAST_STEP, fs);
    write_reg(REG_SLOW_STEP, ss);
    write_reg(REG_BASE_DELAY, bd);
    write_reg(REG_MOD_DEPTH, md);
  endtask

  // valid stays high into the next item when no gap is drawn
  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      sample_in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_in_valid_i <= 1'b1;
    sample_in_i       <= x;
    do @(posedge clk_i); while (sample_in_stall_o);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(SAMPLE_W'($urandom));
    sample_in_valid_i <= 1'b0;
  endtask

  initial begin
    int gap;
    sample_out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        sample_out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      sample_out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!sample_out_valid_o);
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_in_i = '0;
    sample_in_valid_i = 1'b0;
    no_gaps = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'h0001);
    repeat (5) send_sample(16'h7fff);
    repeat (5) send_sample(16'h8000);
    sample_in_valid_i <= 1'b0;
    // delay clamped low, no modulation
    set_all(32'hff00_0000, 0, 0, 0);
    send_random(5);
    // largest base delay, clamped high unless modulation pulls a tap under, full depth, all-ones phase steps wrapping
    set_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_random(6);

    for (int ph = 0; ph < 8; ph++) begin
      no_gaps = (ph % 3 == 1);
      if (ph == 7)
        set_all(32'd2377, 32'd245, 32'd61440, 32'd18432);
      else
        set_all($urandom, $urandom, (ph % 2) ? $urandom_range(0, 262143)
                : $urandom_range(256, 1022 * 256), $urandom);
      send_random(112);
    end
    no_gaps = 1'b0;

    drain();
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
